[src/bcc_pkg.sv]
// Package with shape codes, test kinds and pipeline control types for the collision test.
`timescale 1ns / 1ps

package bcc_pkg;

  // Shape kind codes as they arrive on the shape ports; code 3 behaves as none.
  localparam logic [1:0] SHAPE_NONE   = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;
  localparam logic [1:0] SHAPE_CIRCLE = 2'd2;

  // Kind of test that produced a result.
  typedef enum logic [1:0] {
    TEST_NONE          = 2'd0,
    TEST_BOX_BOX       = 2'd1,
    TEST_CIRCLE_CIRCLE = 2'd2,
    TEST_BOX_CIRCLE    = 2'd3
  } test_kind_e;

  // Control that travels with a transaction between pipeline stages.
  typedef struct packed {
    logic       valid;
    test_kind_e kind;
    logic       hit;
  } stage_ctrl_t;

endpackage

[src/bcc_prep.sv]
// First compute stage: shape decode, edge compares and circle centre offsets.
`timescale 1ns / 1ps

module bcc_prep import bcc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int SIZE_BITS  = 12,
  parameter int DIST_BITS  = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] x_a_i,
  input  logic signed [COORD_BITS-1:0] y_a_i,
  input  logic        [SIZE_BITS-1:0]  width_a_i,
  input  logic        [SIZE_BITS-1:0]  height_a_i,
  input  logic        [1:0]            shape_a_i,
  input  logic signed [COORD_BITS-1:0] x_b_i,
  input  logic signed [COORD_BITS-1:0] y_b_i,
  input  logic        [SIZE_BITS-1:0]  width_b_i,
  input  logic        [SIZE_BITS-1:0]  height_b_i,
  input  logic        [1:0]            shape_b_i,
  output stage_ctrl_t                  ctrl_o,
  output logic        [DIST_BITS-1:0]  dx_o,
  output logic        [DIST_BITS-1:0]  dy_o,
  output logic        [SIZE_BITS-1:0]  sum_o
);

  // Working width: room for a coordinate plus a size with sign, without overflow.
  localparam int WB = DIST_BITS + 1;

  logic signed [WB-1:0] xa, ya, xb, yb;
  logic signed [WB-1:0] wa, ha, wb, hb;
  logic signed [WB-1:0] ra, rb;
  logic [SIZE_BITS-1:0] min_a, min_b;

  logic signed [WB-1:0] bx, by, bw, bh, cx, cy, cr;
  logic signed [WB-1:0] diff_x, diff_y;

  logic        hit_box_box, hit_box_circle;
  stage_ctrl_t ctrl_d, ctrl_q;
  logic [DIST_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SIZE_BITS-1:0] sum_d, sum_q;

  // Extend coordinates by sign and sizes by zero into the working width.
  assign xa = WB'(x_a_i);
  assign ya = WB'(y_a_i);
  assign xb = WB'(x_b_i);
  assign yb = WB'(y_b_i);
  assign wa = $signed({{(WB-SIZE_BITS){1'b0}}, width_a_i});
  assign ha = $signed({{(WB-SIZE_BITS){1'b0}}, height_a_i});
  assign wb = $signed({{(WB-SIZE_BITS){1'b0}}, width_b_i});
  assign hb = $signed({{(WB-SIZE_BITS){1'b0}}, height_b_i});

  // Radius is half the smaller side, rounded down.
  assign min_a = (width_a_i < height_a_i) ? width_a_i : height_a_i;
  assign min_b = (width_b_i < height_b_i) ? width_b_i : height_b_i;
  assign ra    = $signed({{(WB-SIZE_BITS+1){1'b0}}, min_a[SIZE_BITS-1:1]});
  assign rb    = $signed({{(WB-SIZE_BITS+1){1'b0}}, min_b[SIZE_BITS-1:1]});

  // Strict rectangle overlap of both boxes.
  assign hit_box_box = (xa < xb + wb) && (xb < xa + wa) &&
                       (ya < yb + hb) && (yb < ya + ha);

  // Pick which object is the box and which the circle for the mixed test.
  always_comb begin
    if (shape_a_i == SHAPE_BOX) begin
      bx = xa; by = ya; bw = wa; bh = ha;
      cx = xb; cy = yb; cr = rb;
    end else begin
      bx = xb; by = yb; bw = wb; bh = hb;
      cx = xa; cy = ya; cr = ra;
    end
  end

  // The circle's square bounds run from its left/top edge to that edge plus the diameter.
  assign hit_box_circle = (cx + (cr <<< 1) > bx) && (cx < bx + bw) &&
                          (cy + (cr <<< 1) > by) && (cy < by + bh);

  // Centre offsets between the two circles, taken as magnitudes.
  assign diff_x = (xb + rb) - (xa + ra);
  assign diff_y = (yb + rb) - (ya + ra);
  assign dx_d   = diff_x[WB-1] ? DIST_BITS'(-diff_x) : DIST_BITS'(diff_x);
  assign dy_d   = diff_y[WB-1] ? DIST_BITS'(-diff_y) : DIST_BITS'(diff_y);
  assign sum_d  = SIZE_BITS'(ra) + SIZE_BITS'(rb);

  // Decide the test kind; the circle pair finishes in the next stage.
  always_comb begin
    ctrl_d.valid = valid_i;
    ctrl_d.kind  = TEST_NONE;
    ctrl_d.hit   = 1'b0;
    priority if (shape_a_i == SHAPE_BOX && shape_b_i == SHAPE_BOX) begin
      ctrl_d.kind = TEST_BOX_BOX;
      ctrl_d.hit  = hit_box_box;
    end else if (shape_a_i == SHAPE_CIRCLE && shape_b_i == SHAPE_CIRCLE) begin
      ctrl_d.kind = TEST_CIRCLE_CIRCLE;
    end else if ((shape_a_i == SHAPE_BOX && shape_b_i == SHAPE_CIRCLE) ||
                 (shape_a_i == SHAPE_CIRCLE && shape_b_i == SHAPE_BOX)) begin
      ctrl_d.kind = TEST_BOX_CIRCLE;
      ctrl_d.hit  = hit_box_circle;
    end else begin
      ctrl_d.kind = TEST_NONE;
    end
  end

  // Stage register for control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  // Stage register for the distance operands.
  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sum_q <= sum_d;
  end

  assign ctrl_o = ctrl_q;
  assign dx_o   = dx_q;
  assign dy_o   = dy_q;
  assign sum_o  = sum_q;

endmodule

[src/bcc_dist.sv]
// Second compute stage: squared distance compare for circle pairs and the result register.
`timescale 1ns / 1ps

module bcc_dist import bcc_pkg::*; #(
  parameter int SIZE_BITS = 12,
  parameter int DIST_BITS = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stage_ctrl_t          ctrl_i,
  input  logic [DIST_BITS-1:0] dx_i,
  input  logic [DIST_BITS-1:0] dy_i,
  input  logic [SIZE_BITS-1:0] sum_i,
  output logic                 done_o,
  output logic                 hit_o,
  output logic [1:0]           test_kind_o
);

  localparam int SQ_BITS = 2 * DIST_BITS + 1;

  logic [2*DIST_BITS-1:0] dx2, dy2;
  logic [SQ_BITS-1:0]     d2, s2;
  logic [2*SIZE_BITS-1:0] sum2;
  stage_ctrl_t            res_d, res_q;

  // Squares of the centre offsets and of the radius sum.
  assign dx2  = dx_i * dx_i;
  assign dy2  = dy_i * dy_i;
  assign sum2 = sum_i * sum_i;
  assign d2   = SQ_BITS'(dx2) + SQ_BITS'(dy2);
  assign s2   = SQ_BITS'(sum2);

  // Circle pairs take their hit from the distance compare, others pass through.
  always_comb begin
    res_d = ctrl_i;
    if (ctrl_i.kind == TEST_CIRCLE_CIRCLE) begin
      res_d.hit = (d2 < s2);
    end
  end

  // Result register: a transaction is presented for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign done_o      = res_q.valid;
  assign hit_o       = res_q.hit;
  assign test_kind_o = res_q.kind;

endmodule

[src/box_circle_collision_test.sv]
// Top level of the pairwise box and circle collision test.
`timescale 1ns / 1ps

// Takes one pair of objects per transaction and reports whether they collide and which
// test was applied (none, box-box, circle-circle, box-circle). busy_o is always low, so a
// new pair is accepted in every cycle that start_i is high. Each pair passes an input
// register, the edge and offset stage and the squaring stage. Its result appears on the
// result ports, from the result register of the squaring stage, with done_o high for
// exactly one cycle. Results leave in the order the pairs arrived; the receiver cannot
// hold them off.
module box_circle_collision_test import bcc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int SIZE_BITS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] x_a_i,
  input  logic signed [COORD_BITS-1:0] y_a_i,
  input  logic        [SIZE_BITS-1:0]  width_a_i,
  input  logic        [SIZE_BITS-1:0]  height_a_i,
  input  logic        [1:0]            shape_a_i,
  input  logic signed [COORD_BITS-1:0] x_b_i,
  input  logic signed [COORD_BITS-1:0] y_b_i,
  input  logic        [SIZE_BITS-1:0]  width_b_i,
  input  logic        [SIZE_BITS-1:0]  height_b_i,
  input  logic        [1:0]            shape_b_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic        [1:0]            test_kind_o
);

  localparam int DIST_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;

  logic                         valid_q;
  logic signed [COORD_BITS-1:0] x_a_q, y_a_q, x_b_q, y_b_q;
  logic        [SIZE_BITS-1:0]  width_a_q, height_a_q, width_b_q, height_b_q;
  logic        [1:0]            shape_a_q, shape_b_q;

  stage_ctrl_t          prep_ctrl;
  logic [DIST_BITS-1:0] prep_dx, prep_dy;
  logic [SIZE_BITS-1:0] prep_sum;

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    x_a_q      <= x_a_i;
    y_a_q      <= y_a_i;
    width_a_q  <= width_a_i;
    height_a_q <= height_a_i;
    shape_a_q  <= shape_a_i;
    x_b_q      <= x_b_i;
    y_b_q      <= y_b_i;
    width_b_q  <= width_b_i;
    height_b_q <= height_b_i;
    shape_b_q  <= shape_b_i;
  end

  // Edge compares, shape decode and circle offsets.
  bcc_prep #(
    .COORD_BITS (COORD_BITS),
    .SIZE_BITS  (SIZE_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_q),
    .x_a_i      (x_a_q),
    .y_a_i      (y_a_q),
    .width_a_i  (width_a_q),
    .height_a_i (height_a_q),
    .shape_a_i  (shape_a_q),
    .x_b_i      (x_b_q),
    .y_b_i      (y_b_q),
    .width_b_i  (width_b_q),
    .height_b_i (height_b_q),
    .shape_b_i  (shape_b_q),
    .ctrl_o     (prep_ctrl),
    .dx_o       (prep_dx),
    .dy_o       (prep_dy),
    .sum_o      (prep_sum)
  );

  // Squared distance compare and result register.
  bcc_dist #(
    .SIZE_BITS (SIZE_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (prep_ctrl),
    .dx_i        (prep_dx),
    .dy_i        (prep_dy),
    .sum_i       (prep_sum),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .test_kind_o (test_kind_o)
  );

endmodule
